// ----- rtl/acb_pkg.sv -----
// Shared constants, command and status types for the auto-crop bounding box unit.
// Depends on nothing; every other file imports it.
package acb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int AW         = XW + YW;
  localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W      = 9;
  localparam int PIXEL_W    = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    PH_COL,
    PH_ROW,
    PH_BOX
  } scan_phase_t;

  typedef struct packed {
    logic        load;
    logic        cfg_write;
    logic        scan_init;
    scan_phase_t phase;
  } acb_cmd_t;

  typedef struct packed {
    logic last_pixel;
    logic edge_uniform;
    logic scan_done;
    logic scan_ok;
  } acb_status_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/auto_crop_bounding_box_unit.sv -----
// Top level of the auto-crop bounding box unit.
// Depends on acb_pkg, acb_controller and acb_datapath.
//
// Usage: set image_width (index 0) and image_height (index 1) over the cfg
// channel (cfg_valid/cfg_ready, cfg_index, cfg_data); a size write restarts
// the image at its top-left pixel. A value of 0 acts as 1, a value above
// 256 acts as 256. Both reset to 256.
// Pixels enter in raster order, one transfer per cycle, while busy is low:
// a pixel is taken at each edge with start high and busy low. busy is also
// high while cfg_valid is high, so a size write takes precedence.
// The last pixel of an image starts the scan of the frame store (one write port, one read port).
// With a uniform top row or left column, the box scan follows the last pixel;
// else a right-column check runs first, then a bottom-row check if that fails;
// if both fail, no box scan runs and found is low. busy is high throughout.
// done is high for one cycle with found and the crop box; the receiver
// cannot stall, so the result must be taken in that cycle.
// Reset (rst, synchronous) empties the image in progress and restores the
// sizes; frame store contents are left as they are.
module auto_crop_bounding_box_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [acb_pkg::PIXEL_W-1:0]   pixel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acb_pkg::DIM_W-1:0]     cfg_data,
  output logic                          done,
  output logic                          found,
  output logic [7:0]                    crop_left,
  output logic [7:0]                    crop_top,
  output logic [8:0]                    crop_width,
  output logic [8:0]                    crop_height
);
  import acb_pkg::*;

  acb_cmd_t    cmd;
  acb_status_t status;

  acb_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .done      (done)
  );

  acb_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel       (pixel),
    .found       (found),
    .crop_left   (crop_left),
    .crop_top    (crop_top),
    .crop_width  (crop_width),
    .crop_height (crop_height)
  );

endmodule

// ----- rtl/acb_datapath.sv -----
// Datapath: size registers, frame store, load counters, edge checks and box accumulation.
// Depends on acb_pkg; driven by acb_controller through acb_cmd_t.
module acb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  acb_pkg::acb_cmd_t             cmd,
  output acb_pkg::acb_status_t          status,
  input  logic [acb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acb_pkg::DIM_W-1:0]     cfg_data,
  input  logic [acb_pkg::PIXEL_W-1:0]   pixel,
  output logic                          found,
  output logic [7:0]                    crop_left,
  output logic [7:0]                    crop_top,
  output logic [8:0]                    crop_width,
  output logic [8:0]                    crop_height
);
  import acb_pkg::*;

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [DIM_W-1:0]   w_eff;
  logic [DIM_W-1:0]   h_eff;
  logic [DIM_W-1:0]   w_m1;
  logic [DIM_W-1:0]   h_m1;
  logic [XW-1:0]      w_last;
  logic [YW-1:0]      h_last;

  logic [PIXEL_W-1:0] frame_mem [MEM_DEPTH];

  logic [XW-1:0]      lx;
  logic [YW-1:0]      ly;
  logic               top_uniform;
  logic               left_uniform;
  logic [PIXEL_W-1:0] corner;
  logic [PIXEL_W-1:0] bg;
  logic               first_px;
  logic [PIXEL_W-1:0] corner_eff;
  logic               top_next;
  logic               left_next;
  logic               last_px;

  logic               active;
  logic [XW-1:0]      sx;
  logic [YW-1:0]      sy;
  logic               ok;
  logic               rd_valid;
  logic               rd_last;
  logic [XW-1:0]      rd_x;
  logic [YW-1:0]      rd_y;
  logic [PIXEL_W-1:0] rd_data;
  logic [XW-1:0]      iss_x;
  logic [YW-1:0]      iss_y;
  logic               iss_last;
  logic               rd_diff;

  logic [XW-1:0]      min_x;
  logic [XW-1:0]      max_x;
  logic [YW-1:0]      min_y;
  logic [YW-1:0]      max_y;
  logic               nonempty;

  assign w_eff  = clamp_dim(image_width, MAX_W_DIM);
  assign h_eff  = clamp_dim(image_height, MAX_H_DIM);
  assign w_m1   = w_eff - DIM_W'(1);
  assign h_m1   = h_eff - DIM_W'(1);
  assign w_last = w_m1[XW-1:0];
  assign h_last = h_m1[YW-1:0];

  assign first_px   = (lx == '0) && (ly == '0);
  assign corner_eff = first_px ? pixel : corner;
  assign top_next   = top_uniform && !((ly == '0) && (pixel != corner_eff));
  assign left_next  = left_uniform && !((lx == '0) && (pixel != corner_eff));
  assign last_px    = (lx == w_last) && (ly == h_last);

  always_comb begin
    case (cmd.phase)
      PH_COL: begin
        iss_x    = w_last;
        iss_y    = sy;
        iss_last = (sy == h_last);
      end
      PH_ROW: begin
        iss_x    = sx;
        iss_y    = h_last;
        iss_last = (sx == w_last);
      end
      default: begin
        iss_x    = sx;
        iss_y    = sy;
        iss_last = (sx == w_last) && (sy == h_last);
      end
    endcase
  end

  assign rd_diff = (rd_data != bg);

  assign status.last_pixel   = last_px;
  assign status.edge_uniform = top_next || left_next;
  assign status.scan_done    = rd_valid && rd_last;
  assign status.scan_ok      = ok && !(rd_valid && rd_diff);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      frame_mem[{ly, lx}] <= pixel;
    end
    rd_data <= frame_mem[{iss_y, iss_x}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= MAX_W_DIM;
      image_height <= MAX_H_DIM;
      lx           <= '0;
      ly           <= '0;
      top_uniform  <= 1'b1;
      left_uniform <= 1'b1;
      active       <= 1'b0;
      rd_valid     <= 1'b0;
      nonempty     <= 1'b0;
    end else if (cmd.cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          image_width  <= cfg_data;
          lx           <= '0;
          ly           <= '0;
          top_uniform  <= 1'b1;
          left_uniform <= 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          lx           <= '0;
          ly           <= '0;
          top_uniform  <= 1'b1;
          left_uniform <= 1'b1;
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd.load) begin
        corner <= corner_eff;
        if (last_px) begin
          lx           <= '0;
          ly           <= '0;
          top_uniform  <= 1'b1;
          left_uniform <= 1'b1;
          bg           <= (top_next || left_next) ? corner_eff : pixel;
          min_x        <= '1;
          min_y        <= '1;
          max_x        <= '0;
          max_y        <= '0;
          nonempty     <= 1'b0;
        end else begin
          top_uniform  <= top_next;
          left_uniform <= left_next;
          if (lx == w_last) begin
            lx <= '0;
            ly <= ly + YW'(1);
          end else begin
            lx <= lx + XW'(1);
          end
        end
      end

      rd_valid <= active;
      if (active) begin
        rd_x    <= iss_x;
        rd_y    <= iss_y;
        rd_last <= iss_last;
        if (iss_last) begin
          active <= 1'b0;
        end
        case (cmd.phase)
          PH_COL: begin
            sy <= sy + YW'(1);
          end
          PH_ROW: begin
            sx <= sx + XW'(1);
          end
          default: begin
            if (sx == w_last) begin
              sx <= '0;
              sy <= sy + YW'(1);
            end else begin
              sx <= sx + XW'(1);
            end
          end
        endcase
      end

      if (rd_valid && rd_diff) begin
        ok <= 1'b0;
        if (cmd.phase == PH_BOX) begin
          nonempty <= 1'b1;
          if (rd_x < min_x) begin
            min_x <= rd_x;
          end
          if (rd_x > max_x) begin
            max_x <= rd_x;
          end
          if (rd_y < min_y) begin
            min_y <= rd_y;
          end
          if (rd_y > max_y) begin
            max_y <= rd_y;
          end
        end
      end

      if (cmd.scan_init) begin
        active <= 1'b1;
        sx     <= '0;
        sy     <= '0;
        ok     <= 1'b1;
      end
    end
  end

  assign found       = nonempty;
  assign crop_left   = nonempty ? 8'(min_x) : 8'd0;
  assign crop_top    = nonempty ? 8'(min_y) : 8'd0;
  assign crop_width  = nonempty ? (9'(max_x) - 9'(min_x) + 9'd1) : 9'd0;
  assign crop_height = nonempty ? (9'(max_y) - 9'(min_y) + 9'd1) : 9'd0;

endmodule

// ----- rtl/acb_controller.sv -----
// Controller: sequences load, right-column check, bottom-row check, box scan and result.
// Depends on acb_pkg; commands acb_datapath through acb_cmd_t.
module acb_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 cfg_valid,
  input  acb_pkg::acb_status_t status,
  output acb_pkg::acb_cmd_t    cmd,
  output logic                 busy,
  output logic                 cfg_ready,
  output logic                 done
);
  import acb_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_COL,
    S_ROW,
    S_BOX,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign busy      = (state != S_LOAD) || cfg_valid;
  assign cfg_ready = (state == S_LOAD);

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.cfg_write = cfg_valid && (state == S_LOAD);
    cmd.scan_init = 1'b0;
    case (state)
      S_COL:   cmd.phase = PH_COL;
      S_ROW:   cmd.phase = PH_ROW;
      default: cmd.phase = PH_BOX;
    endcase
    case (state)
      S_LOAD: begin
        cmd.load = start && !cmd.cfg_write;
        if (cmd.load && status.last_pixel) begin
          cmd.scan_init = 1'b1;
          state_next    = status.edge_uniform ? S_BOX : S_COL;
        end
      end
      S_COL: begin
        if (status.scan_done) begin
          cmd.scan_init = 1'b1;
          state_next    = status.scan_ok ? S_BOX : S_ROW;
        end
      end
      S_ROW: begin
        if (status.scan_done) begin
          if (status.scan_ok) begin
            cmd.scan_init = 1'b1;
            state_next    = S_BOX;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_BOX: begin
        if (status.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state_next == S_EMIT);
    end
  end

endmodule
